FILE: hdl/gfd_pkg.sv
// Shared widths, register indexes and reset values for the gradient filter decoder.
package gfd_pkg;

  localparam int CHAN_W             = 16;
  localparam int WORD_W             = 32;
  localparam int WIDTH_W            = 12;
  localparam int SHIFT_W            = 5;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 16;
  localparam int MAX_ROW_PIXELS_DEF = 2048;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECT_WIDTH  = 3'd0,
    CFG_RED_MAX     = 3'd1,
    CFG_GREEN_MAX   = 3'd2,
    CFG_BLUE_MAX    = 3'd3,
    CFG_RED_SHIFT   = 3'd4,
    CFG_GREEN_SHIFT = 3'd5,
    CFG_BLUE_SHIFT  = 3'd6
  } cfg_idx_t;

  // Register reset values
  localparam logic [WIDTH_W-1:0] RST_RECT_WIDTH  = 12'd1;
  localparam logic [CHAN_W-1:0]  RST_CHAN_MAX    = 16'h00FF;
  localparam logic [SHIFT_W-1:0] RST_RED_SHIFT   = 5'd16;
  localparam logic [SHIFT_W-1:0] RST_GREEN_SHIFT = 5'd8;
  localparam logic [SHIFT_W-1:0] RST_BLUE_SHIFT  = 5'd0;

  // One pixel of three channels
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

endpackage

FILE: hdl/gfd_if.sv
// Valid/ready stream interfaces for residual input words and pixel output words.
interface gfd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      start_of_rect;
  logic [gfd_pkg::CHAN_W-1:0] red_residual;
  logic [gfd_pkg::CHAN_W-1:0] green_residual;
  logic [gfd_pkg::CHAN_W-1:0] blue_residual;

  modport source (
    output valid, start_of_rect, red_residual, green_residual, blue_residual,
    input  ready
  );
  modport sink (
    input  valid, start_of_rect, red_residual, green_residual, blue_residual,
    output ready
  );
endinterface

interface gfd_out_if;
  logic                      valid;
  logic                      ready;
  logic [gfd_pkg::WORD_W-1:0] pixel_word;
  logic                      row_end;

  modport source (
    output valid, pixel_word, row_end,
    input  ready
  );
  modport sink (
    input  valid, pixel_word, row_end,
    output ready
  );
endinterface

FILE: hdl/gradient_filter_decoder_core.sv
// Gradient filter decoder: row store, predictor pipeline and output register.
//
// Usage: residual words arrive on in_ch (valid/ready), one pixel per word in
// raster order; start_of_rect marks the first pixel of a rectangle. Each word
// gives exactly one word on out_ch: the rebuilt pixel, shifted and packed into
// 32 bits, with row_end set on the last pixel of each row.
// Registers (width, channel maxima, shifts) are to be written on the cfg_ port
// only while no pixel is in flight; the block itself does not enforce this.
// Throughput: one pixel per cycle while out_ch does not stall, set by the
// single read-modify-write pass over the row store (one read port, one write
// port) and the registered left/upper-left pixels; a store entry written and
// read at the same edge is forwarded. An accepted word enters the prediction
// stage as its entry above is read, then predicted and packed into out_word_r.
// Reset (rst_n low, synchronous) loads the register defaults, empties the
// pipeline and starts at column 0 of a first row; the row store is not
// cleared, as the first row of a rectangle never uses it.
// When out_ch stalls, the finished word holds in the output register and a
// word is still taken into the prediction stage only while it is empty; once
// it is full, in_ch.ready drops until the output drains.
module gradient_filter_decoder_core #(
  parameter int MAX_ROW_PIXELS = gfd_pkg::MAX_ROW_PIXELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gfd_in_if.sink                        in_ch,
  gfd_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [gfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W = $clog2(MAX_ROW_PIXELS);
  localparam int CMP_W = (COL_W + 1 > gfd_pkg::WIDTH_W) ? COL_W + 1 : gfd_pkg::WIDTH_W;
  localparam int PIX_W = $bits(gfd_pkg::pix_t);
  localparam int CH_W  = gfd_pkg::CHAN_W;
  localparam int SH_W  = gfd_pkg::SHIFT_W;

  // Configuration registers
  logic [gfd_pkg::WIDTH_W-1:0] rect_width_r;
  logic [CH_W-1:0]             red_max_r, green_max_r, blue_max_r;
  logic [SH_W-1:0]             red_shift_r, green_shift_r, blue_shift_r;

  // Row position state
  logic [COL_W-1:0] column_r;
  logic             first_row_r;

  // Prediction stage
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_first_r;
  logic             s1_row_end_r;
  gfd_pkg::pix_t    s1_res_r;
  logic             s1_fwd_r;
  gfd_pkg::pix_t    fwd_pix_r;
  gfd_pkg::pix_t    mem_q_r;

  // Neighbour pixels
  gfd_pkg::pix_t left_r;
  gfd_pkg::pix_t upper_left_r;

  // Output register
  logic                      out_valid_r;
  logic [gfd_pkg::WORD_W-1:0] out_word_r;
  logic                      out_row_end_r;

  // Row store
  logic [PIX_W-1:0] row_mem [MAX_ROW_PIXELS];

  logic             s1_adv;
  logic             in_acc;
  logic [COL_W-1:0] rd_col;
  logic             rd_first;
  logic             rd_last;
  gfd_pkg::pix_t    above;
  gfd_pkg::pix_t    pix;
  logic [gfd_pkg::WORD_W-1:0] word;
  logic             s1_col0;

  // Rebuild one channel from its neighbours and residual
  function automatic logic [CH_W-1:0] recon(
    input logic [CH_W-1:0] up,
    input logic [CH_W-1:0] lf,
    input logic [CH_W-1:0] ul,
    input logic [CH_W-1:0] mx,
    input logic [CH_W-1:0] res,
    input logic            col0
  );
    logic signed [CH_W+1:0] est;
    logic [CH_W-1:0]        pred;
    logic [CH_W:0]          sum;
    est = $signed({2'b00, up}) + $signed({2'b00, lf}) - $signed({2'b00, ul});
    if (col0) begin
      pred = up;
    end else if (est > $signed({2'b00, mx})) begin
      pred = mx;
    end else if (est < 0) begin
      pred = '0;
    end else begin
      pred = est[CH_W-1:0];
    end
    sum = {1'b0, res} + {1'b0, pred};
    return sum[CH_W-1:0] & mx;
  endfunction

  // Handshake: stage advances when the output register is free or draining
  assign s1_adv       = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_word = out_word_r;
  assign out_ch.row_end    = out_row_end_r;

  // Column of the incoming word and end-of-row test
  always_comb begin
    if (in_ch.start_of_rect) begin
      rd_col   = '0;
      rd_first = 1'b1;
    end else begin
      rd_col   = column_r;
      rd_first = first_row_r;
    end
    rd_last = (rect_width_r == '0) ||
              (rd_col == COL_W'(MAX_ROW_PIXELS - 1)) ||
              ((CMP_W'(rd_col) + CMP_W'(1)) >= CMP_W'(rect_width_r));
  end

  // Predict and pack
  always_comb begin
    if (s1_first_r) begin
      above = '0;
    end else if (s1_fwd_r) begin
      above = fwd_pix_r;
    end else begin
      above = mem_q_r;
    end
    s1_col0   = (s1_col_r == '0);
    pix.red   = recon(above.red, left_r.red, upper_left_r.red, red_max_r,
                      s1_res_r.red, s1_col0);
    pix.green = recon(above.green, left_r.green, upper_left_r.green, green_max_r,
                      s1_res_r.green, s1_col0);
    pix.blue  = recon(above.blue, left_r.blue, upper_left_r.blue, blue_max_r,
                      s1_res_r.blue, s1_col0);
    word = (gfd_pkg::WORD_W'(pix.red) << red_shift_r) |
           (gfd_pkg::WORD_W'(pix.green) << green_shift_r) |
           (gfd_pkg::WORD_W'(pix.blue) << blue_shift_r);
  end

  // Row store: write back the finished pixel, read the entry above the next one
  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      row_mem[s1_col_r] <= pix;
    end
    if (in_acc) begin
      mem_q_r <= row_mem[rd_col];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_width_r  <= gfd_pkg::RST_RECT_WIDTH;
      red_max_r     <= gfd_pkg::RST_CHAN_MAX;
      green_max_r   <= gfd_pkg::RST_CHAN_MAX;
      blue_max_r    <= gfd_pkg::RST_CHAN_MAX;
      red_shift_r   <= gfd_pkg::RST_RED_SHIFT;
      green_shift_r <= gfd_pkg::RST_GREEN_SHIFT;
      blue_shift_r  <= gfd_pkg::RST_BLUE_SHIFT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gfd_pkg::CFG_RECT_WIDTH:  rect_width_r  <= cfg_wdata[gfd_pkg::WIDTH_W-1:0];
        gfd_pkg::CFG_RED_MAX:     red_max_r     <= cfg_wdata[CH_W-1:0];
        gfd_pkg::CFG_GREEN_MAX:   green_max_r   <= cfg_wdata[CH_W-1:0];
        gfd_pkg::CFG_BLUE_MAX:    blue_max_r    <= cfg_wdata[CH_W-1:0];
        gfd_pkg::CFG_RED_SHIFT:   red_shift_r   <= cfg_wdata[SH_W-1:0];
        gfd_pkg::CFG_GREEN_SHIFT: green_shift_r <= cfg_wdata[SH_W-1:0];
        gfd_pkg::CFG_BLUE_SHIFT:  blue_shift_r  <= cfg_wdata[SH_W-1:0];
        default: ;
      endcase
    end
  end

  // Row position and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      first_row_r  <= 1'b1;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      left_r       <= '0;
      upper_left_r <= '0;
    end else begin
      // advance the column on each accepted word
      if (in_acc) begin
        if (rd_last) begin
          column_r    <= '0;
          first_row_r <= 1'b0;
        end else begin
          column_r    <= rd_col + COL_W'(1);
          first_row_r <= rd_first;
        end
      end
      // hold or refill the prediction stage
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      // update neighbours as the pixel leaves
      if (s1_valid_r && s1_adv) begin
        left_r       <= pix;
        upper_left_r <= above;
      end
      // load or drain the output register
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r       <= rd_col;
      s1_first_r     <= rd_first;
      s1_row_end_r   <= rd_last;
      s1_res_r.red   <= in_ch.red_residual;
      s1_res_r.green <= in_ch.green_residual;
      s1_res_r.blue  <= in_ch.blue_residual;
      // forward a pixel written to the entry being read at this edge
      s1_fwd_r       <= s1_valid_r && s1_adv && (s1_col_r == rd_col);
      fwd_pix_r      <= pix;
    end
    if (s1_valid_r && s1_adv) begin
      out_word_r    <= word;
      out_row_end_r <= s1_row_end_r;
    end
  end

endmodule
